// ===== src/tcpq_pkg.sv =====
// Package with the shared types and codes of the two-class priority queue.
package tcpq_pkg;

  // Operation codes carried by a command beat.
  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_PROMOTE = 3'd2,
    OP_TIME    = 3'd3,
    OP_REMOVE  = 3'd4
  } op_t;

  // Status codes returned with every response beat.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_t;

  // Configuration register indexes.
  localparam logic CFG_ELDER_AGE      = 1'b0;
  localparam logic CFG_WAIT_THRESHOLD = 1'b1;

  localparam int CFG_DATA_W = 10;

  // Command beat.
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ticket;
    logic [6:0]  age;
    logic        health_worker;
    logic [9:0]  current_time;
  } cmd_t;

  // Response beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_ticket;
    logic        out_priority;
    logic        out_emergency;
    logic [6:0]  entry_count;
  } rsp_t;

  // Payload held by one cell.
  typedef struct packed {
    logic [15:0] tk;
    logic        pr;
    logic        em;
  } slot_t;

  // Cell content as seen by its neighbors.
  typedef struct packed {
    logic  v;
    slot_t s;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        go;
    op_t         op;
    logic [15:0] ticket;
    logic        new_pr;
    logic        full;
    logic        empty;
    logic        found;
    logic        sel_pr;
    logic        time_hit;
  } cell_ctrl_t;

endpackage

// ===== src/two_class_priority_queue.sv =====
// Top level of the two-class priority queue: sequencer, cell chain and response register.
//
// The queue holds up to DEPTH tickets in a chain of cells, priority entries at
// the head and normal entries behind them, each group in arrival order. A
// command beat is taken when the block is idle and the response register is
// free or being emptied; the cell chain then updates in the following cycle,
// when all cells compare the ticket at once and shift toward the head or the
// tail, and the response beat is registered in that same update. The cell
// chain takes each command in a single update step; stalls on the response
// side hold off the next command. The configuration port is always ready and
// is meant to be written only while no command is in flight.
module two_class_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  tcpq_pkg::cmd_t                      cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output tcpq_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [tcpq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);

  tcpq_pkg::seq_t       state;
  tcpq_pkg::seq_t       state_next;
  logic                 cmd_accept;
  tcpq_pkg::cmd_t       cmd_reg;
  logic [6:0]           elder_age;
  logic [9:0]           wait_threshold;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  tcpq_pkg::rsp_t       rsp_next;
  tcpq_pkg::cell_ctrl_t ctrl;
  tcpq_pkg::op_t        op;
  tcpq_pkg::slot_t      sel;

  tcpq_pkg::entry_t ents   [DEPTH];
  logic             keeps  [DEPTH];
  logic             prvs   [DEPTH];
  logic             firsts [DEPTH];
  logic             seen   [DEPTH+1];

  assign cfg_ready  = 1'b1;
  assign op         = tcpq_pkg::op_t'(cmd_reg.op);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      elder_age      <= 7'd60;
      wait_threshold <= 10'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcpq_pkg::CFG_ELDER_AGE:      elder_age      <= cfg_data[6:0];
        tcpq_pkg::CFG_WAIT_THRESHOLD: wait_threshold <= cfg_data;
        default: begin
          elder_age <= elder_age;
        end
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpq_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and command handshake.
  always_comb begin
    cmd_stall  = (state == tcpq_pkg::SEQ_EXEC) | (rsp_valid & rsp_stall);
    cmd_accept = cmd_valid & ~cmd_stall;
    case (state)
      tcpq_pkg::SEQ_IDLE: state_next = cmd_accept ? tcpq_pkg::SEQ_EXEC : tcpq_pkg::SEQ_IDLE;
      tcpq_pkg::SEQ_EXEC: state_next = tcpq_pkg::SEQ_IDLE;
      default:            state_next = tcpq_pkg::SEQ_IDLE;
    endcase
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_reg <= cmd;
    end
  end

  // Broadcast control for the cells.
  always_comb begin
    ctrl.go       = (state == tcpq_pkg::SEQ_EXEC);
    ctrl.op       = op;
    ctrl.ticket   = cmd_reg.ticket;
    ctrl.new_pr   = (cmd_reg.age >= elder_age) | cmd_reg.health_worker;
    ctrl.full     = (count == CW'(DEPTH));
    ctrl.empty    = (count == '0);
    ctrl.found    = seen[DEPTH];
    ctrl.sel_pr   = sel.pr;
    ctrl.time_hit = (cmd_reg.current_time > wait_threshold);
  end

  // Cell chain.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tcpq_pkg::entry_t left_ent;
    tcpq_pkg::entry_t right_ent;
    logic             left_keep;
    logic             left_edge;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_keep = 1'b1;
      assign left_edge = 1'b1;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign left_keep = keeps[i-1];
      assign left_edge = prvs[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    tcpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_ent),
      .left_keep (left_keep),
      .left_edge (left_edge),
      .right     (right_ent),
      .seen_in   (seen[i]),
      .ent       (ents[i]),
      .keep      (keeps[i]),
      .pr_valid  (prvs[i]),
      .seen_out  (seen[i+1]),
      .first     (firsts[i])
    );
  end

  // Gather the first matching entry; at most one cell flags itself as first.
  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (firsts[i]) begin
        sel = sel | ents[i].s;
      end
    end
  end

  // Response and count for the current operation.
  always_comb begin
    count_next           = count;
    rsp_next.status      = tcpq_pkg::ST_OK;
    rsp_next.out_ticket  = '0;
    rsp_next.out_priority  = 1'b0;
    rsp_next.out_emergency = 1'b0;
    case (op)
      tcpq_pkg::OP_ENQUEUE: begin
        if (ctrl.full) begin
          rsp_next.status = tcpq_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      tcpq_pkg::OP_DEQUEUE: begin
        if (ctrl.empty) begin
          rsp_next.status = tcpq_pkg::ST_EMPTY;
        end else begin
          rsp_next.out_ticket    = ents[0].s.tk;
          rsp_next.out_priority  = ents[0].s.pr;
          rsp_next.out_emergency = ents[0].s.em;
          count_next             = count - CW'(1);
        end
      end
      tcpq_pkg::OP_PROMOTE: begin
        if (!ctrl.found) begin
          rsp_next.status = tcpq_pkg::ST_NOTFOUND;
        end
      end
      tcpq_pkg::OP_REMOVE: begin
        if (!ctrl.found) begin
          rsp_next.status = tcpq_pkg::ST_NOTFOUND;
        end else begin
          rsp_next.out_ticket    = sel.tk;
          rsp_next.out_priority  = sel.pr;
          rsp_next.out_emergency = sel.em;
          count_next             = count - CW'(1);
        end
      end
      default: begin
        rsp_next.status = tcpq_pkg::ST_OK;
      end
    endcase
    rsp_next.entry_count = 7'(count_next);
  end

  // Occupancy counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == tcpq_pkg::SEQ_EXEC) begin
      count <= count_next;
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == tcpq_pkg::SEQ_EXEC) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (state == tcpq_pkg::SEQ_EXEC) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/tcpq_cell.sv =====
// One cell of the queue chain: holds one entry and trades it with its neighbors.
module tcpq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  tcpq_pkg::cell_ctrl_t ctrl,
  input  tcpq_pkg::entry_t     left,
  input  logic                 left_keep,
  input  logic                 left_edge,
  input  tcpq_pkg::entry_t     right,
  input  logic                 seen_in,
  output tcpq_pkg::entry_t     ent,
  output logic                 keep,
  output logic                 pr_valid,
  output logic                 seen_out,
  output logic                 first
);

  logic            vld;
  tcpq_pkg::slot_t slot;
  logic            vld_next;
  tcpq_pkg::slot_t slot_next;
  logic            match;

  assign ent      = '{v: vld, s: slot};
  assign pr_valid = vld & slot.pr;

  // An enqueue leaves this cell in place when the new entry belongs behind it.
  assign keep = vld & (slot.pr | ~ctrl.new_pr);

  // Search chain: a match is the first one when no cell nearer the head matched.
  assign match    = vld & (slot.tk == ctrl.ticket);
  assign first    = match & ~seen_in;
  assign seen_out = seen_in | match;

  // Next content of the cell for the current operation.
  always_comb begin
    vld_next  = vld;
    slot_next = slot;
    if (ctrl.go) begin
      case (ctrl.op)
        tcpq_pkg::OP_ENQUEUE: begin
          if (!ctrl.full && !keep) begin
            if (left_keep) begin
              vld_next  = 1'b1;
              slot_next = '{tk: ctrl.ticket, pr: ctrl.new_pr, em: 1'b0};
            end else begin
              vld_next  = left.v;
              slot_next = left.s;
            end
          end
        end
        tcpq_pkg::OP_DEQUEUE: begin
          if (!ctrl.empty) begin
            vld_next  = right.v;
            slot_next = right.s;
          end
        end
        tcpq_pkg::OP_PROMOTE: begin
          if (ctrl.found) begin
            if (ctrl.sel_pr) begin
              if (first) begin
                slot_next.em = 1'b1;
              end
            end else if (vld && !slot.pr && !seen_in) begin
              // Normal cells up to the match shift back by one; the first
              // normal cell takes the promoted ticket.
              if (left_edge) begin
                slot_next = '{tk: ctrl.ticket, pr: 1'b1, em: 1'b1};
              end else begin
                slot_next = left.s;
              end
            end
          end
        end
        tcpq_pkg::OP_TIME: begin
          if (ctrl.time_hit && vld) begin
            slot_next.pr = 1'b1;
          end
        end
        tcpq_pkg::OP_REMOVE: begin
          if (ctrl.found && seen_out) begin
            vld_next  = right.v;
            slot_next = right.s;
          end
        end
        default: begin
          vld_next  = vld;
          slot_next = slot;
        end
      endcase
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule
